>>> src/adsr_pkg.sv
package adsr_pkg;

    localparam int FRAC_BITS = 24;
    localparam int COEFF_W   = 24;
    localparam int LEVEL_W   = 25;
    localparam int CV_W      = 26;
    localparam int FUNC_W    = 3;
    localparam int CFG_IDX_W = 3;
    localparam int DIFF_W    = LEVEL_W + 2;
    localparam int STEP_W    = DIFF_W + 1;
    localparam int PROD_W    = COEFF_W + 1 + DIFF_W;

    localparam int EPS_INT = ((1 << FRAC_BITS) + 500) / 1000;

    localparam logic signed [STEP_W-1:0] ONE_FX   = STEP_W'(1) << FRAC_BITS;
    localparam logic signed [STEP_W-1:0] EPS_FX   = STEP_W'(EPS_INT);
    localparam logic signed [CV_W-1:0]   HALF_CV  = CV_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [PROD_W-1:0] ROUND_FX = PROD_W'(1) << (FRAC_BITS - 1);

    // function codes
    localparam logic [FUNC_W-1:0] FN_TICK     = 3'd0;
    localparam logic [FUNC_W-1:0] FN_GATE     = 3'd1;
    localparam logic [FUNC_W-1:0] FN_TRIG     = 3'd2;
    localparam logic [FUNC_W-1:0] FN_NOTE_ON  = 3'd3;
    localparam logic [FUNC_W-1:0] FN_NOTE_OFF = 3'd4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ATTACK_COEFF   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY_COEFF    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_COEFF  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN_LEVEL  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ATTACK_TARGET  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_TARGET = 3'd5;

    localparam logic [COEFF_W-1:0]        RST_ATTACK_COEFF   = 24'd16700598;
    localparam logic [COEFF_W-1:0]        RST_DECAY_COEFF    = 24'd16769538;
    localparam logic [COEFF_W-1:0]        RST_RELEASE_COEFF  = 24'd16773376;
    localparam logic [LEVEL_W-1:0]        RST_SUSTAIN_LEVEL  = 25'd11744051;
    localparam logic [LEVEL_W-1:0]        RST_ATTACK_TARGET  = 25'd20132659;
    localparam logic signed [LEVEL_W-1:0] RST_RELEASE_TARGET = -25'sd16777;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_ATTACK,
        PH_DECAY,
        PH_SUSTAIN,
        PH_RELEASE
    } phase_t;

endpackage

>>> src/adsr_pole.sv
module adsr_pole (
    input  logic [adsr_pkg::COEFF_W-1:0]       coeff,
    input  logic [adsr_pkg::LEVEL_W-1:0]       cur_level,
    input  logic signed [adsr_pkg::DIFF_W-1:0] target,
    output logic signed [adsr_pkg::STEP_W-1:0] step
);

    logic signed [adsr_pkg::STEP_W-1:0]  coeff_ext;
    logic signed [adsr_pkg::STEP_W-1:0]  coeff_sat;
    logic signed [adsr_pkg::COEFF_W:0]   coeff_s;
    logic signed [adsr_pkg::DIFF_W-1:0]  diff;
    logic signed [adsr_pkg::PROD_W-1:0]  prod;
    logic signed [adsr_pkg::PROD_W-1:0]  rounded;

    // a pole of 1.0 or more saturates just below 1.0
    assign coeff_ext = signed'(adsr_pkg::STEP_W'(coeff));
    assign coeff_sat = (coeff_ext >= adsr_pkg::ONE_FX)
                       ? (adsr_pkg::ONE_FX - signed'(adsr_pkg::STEP_W'(1)))
                       : coeff_ext;
    assign coeff_s   = coeff_sat[adsr_pkg::COEFF_W:0];

    assign diff    = signed'(adsr_pkg::DIFF_W'(cur_level)) - target;
    assign prod    = adsr_pkg::PROD_W'(coeff_s * diff);
    // round to nearest, ties toward +inf
    assign rounded = (prod + adsr_pkg::ROUND_FX) >>> adsr_pkg::FRAC_BITS;
    assign step    = signed'(adsr_pkg::STEP_W'(target)) + rounded[adsr_pkg::STEP_W-1:0];

endmodule

>>> src/adsr_envelope_generator_unit.sv
// An accepted word is held in the input register; a tick loads the output register.
// Throughput: one word per cycle while out_stall is low; the envelope state is updated
// in a single pass through one 25x27 multiply-round stage, so each word sees the
// previous one's result. Non-tick words update state and produce no output word.
// Reset (rst_n, asynchronous): phase idle, level zero, CV edge history low,
// registers back to their default values.
module adsr_envelope_generator_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [adsr_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [adsr_pkg::LEVEL_W-1:0]          cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [adsr_pkg::FUNC_W-1:0]           func,
    input  logic signed [adsr_pkg::CV_W-1:0]      cv_value,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [adsr_pkg::LEVEL_W-1:0]          level
);

    logic [adsr_pkg::COEFF_W-1:0]        attack_coeff_reg;
    logic [adsr_pkg::COEFF_W-1:0]        decay_coeff_reg;
    logic [adsr_pkg::COEFF_W-1:0]        release_coeff_reg;
    logic [adsr_pkg::LEVEL_W-1:0]        sustain_level_reg;
    logic [adsr_pkg::LEVEL_W-1:0]        attack_target_reg;
    logic signed [adsr_pkg::LEVEL_W-1:0] release_target_reg;

    logic                          s1_valid_reg;
    logic                          s1_valid_next;
    logic [adsr_pkg::FUNC_W-1:0]   s1_func_reg;
    logic                          s1_high_reg;
    logic                          s1_is_tick;
    logic                          s1_go;
    logic                          in_take;
    logic                          out_free;

    adsr_pkg::phase_t              phase_reg;
    adsr_pkg::phase_t              phase_next;
    logic [adsr_pkg::LEVEL_W-1:0]  env_level_reg;
    logic [adsr_pkg::LEVEL_W-1:0]  env_level_next;
    logic                          gate_was_high_reg;
    logic                          gate_was_high_next;
    logic                          trig_was_high_reg;
    logic                          trig_was_high_next;

    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [adsr_pkg::LEVEL_W-1:0]  level_reg;

    logic [adsr_pkg::COEFF_W-1:0]        pole_coeff;
    logic signed [adsr_pkg::DIFF_W-1:0]  pole_target;
    logic signed [adsr_pkg::STEP_W-1:0]  step;
    logic signed [adsr_pkg::STEP_W-1:0]  sus_ext;
    logic                                reach_one;
    logic                                reach_sus;
    logic                                reach_zero;

    // ---------------- configuration ----------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_coeff_reg   <= adsr_pkg::RST_ATTACK_COEFF;
            decay_coeff_reg    <= adsr_pkg::RST_DECAY_COEFF;
            release_coeff_reg  <= adsr_pkg::RST_RELEASE_COEFF;
            sustain_level_reg  <= adsr_pkg::RST_SUSTAIN_LEVEL;
            attack_target_reg  <= adsr_pkg::RST_ATTACK_TARGET;
            release_target_reg <= adsr_pkg::RST_RELEASE_TARGET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                adsr_pkg::REG_ATTACK_COEFF:
                    attack_coeff_reg <= cfg_data[adsr_pkg::COEFF_W-1:0];
                adsr_pkg::REG_DECAY_COEFF:
                    decay_coeff_reg <= cfg_data[adsr_pkg::COEFF_W-1:0];
                adsr_pkg::REG_RELEASE_COEFF:
                    release_coeff_reg <= cfg_data[adsr_pkg::COEFF_W-1:0];
                adsr_pkg::REG_SUSTAIN_LEVEL:
                    sustain_level_reg <= cfg_data;
                adsr_pkg::REG_ATTACK_TARGET:
                    attack_target_reg <= cfg_data;
                adsr_pkg::REG_RELEASE_TARGET:
                    release_target_reg <= signed'(cfg_data);
                default:
                    ;
            endcase
        end
    end

    // ---------------- input register and handshake ----------------
    assign s1_is_tick = (s1_func_reg == adsr_pkg::FN_TICK);
    assign out_free   = !out_valid_reg || !out_stall;
    // a tick needs room in the output register, other words always advance
    assign s1_go      = s1_valid_reg && (!s1_is_tick || out_free);
    assign in_stall   = s1_valid_reg && !s1_go;
    assign in_take    = in_valid && !in_stall;

    always_comb
    begin
        if (in_take)
            s1_valid_next = 1'b1;
        else if (s1_go)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_func_reg <= func;
            s1_high_reg <= (cv_value > adsr_pkg::HALF_CV);
        end
    end

    // ---------------- one-pole step ----------------
    assign sus_ext = signed'(adsr_pkg::STEP_W'(sustain_level_reg));

    always_comb
    begin
        case (phase_reg)
            adsr_pkg::PH_ATTACK:
            begin
                pole_coeff  = attack_coeff_reg;
                pole_target = signed'(adsr_pkg::DIFF_W'(attack_target_reg));
            end
            adsr_pkg::PH_DECAY:
            begin
                pole_coeff  = decay_coeff_reg;
                pole_target = adsr_pkg::DIFF_W'(sus_ext - adsr_pkg::EPS_FX);
            end
            default:
            begin
                pole_coeff  = release_coeff_reg;
                pole_target = adsr_pkg::DIFF_W'(release_target_reg);
            end
        endcase
    end

    adsr_pole u_pole (
        .coeff     (pole_coeff),
        .cur_level (env_level_reg),
        .target    (pole_target),
        .step      (step)
    );

    assign reach_one  = (step >= adsr_pkg::ONE_FX);
    assign reach_sus  = (step <= sus_ext);
    assign reach_zero = (step <= 0);

    // ---------------- next phase ----------------
    always_comb
    begin
        phase_next         = phase_reg;
        gate_was_high_next = gate_was_high_reg;
        trig_was_high_next = trig_was_high_reg;
        if (s1_go)
        begin
            case (s1_func_reg)
                adsr_pkg::FN_TICK:
                begin
                    case (phase_reg)
                        adsr_pkg::PH_ATTACK:
                            if (reach_one)
                                phase_next = adsr_pkg::PH_DECAY;
                        adsr_pkg::PH_DECAY:
                            if (reach_sus)
                                phase_next = adsr_pkg::PH_SUSTAIN;
                        adsr_pkg::PH_SUSTAIN:
                            phase_next = adsr_pkg::PH_SUSTAIN;
                        adsr_pkg::PH_RELEASE:
                            if (reach_zero)
                                phase_next = adsr_pkg::PH_IDLE;
                        default:
                            phase_next = adsr_pkg::PH_IDLE;
                    endcase
                end
                adsr_pkg::FN_GATE:
                begin
                    if (s1_high_reg && !gate_was_high_reg)
                        phase_next = adsr_pkg::PH_ATTACK;
                    else if (!s1_high_reg && gate_was_high_reg
                             && phase_reg != adsr_pkg::PH_IDLE)
                        phase_next = adsr_pkg::PH_RELEASE;
                    gate_was_high_next = s1_high_reg;
                end
                adsr_pkg::FN_TRIG:
                begin
                    if (s1_high_reg && !trig_was_high_reg)
                        phase_next = adsr_pkg::PH_ATTACK;
                    trig_was_high_next = s1_high_reg;
                end
                adsr_pkg::FN_NOTE_ON:
                    phase_next = adsr_pkg::PH_ATTACK;
                adsr_pkg::FN_NOTE_OFF:
                    if (phase_reg != adsr_pkg::PH_IDLE)
                        phase_next = adsr_pkg::PH_RELEASE;
                default:
                    ;
            endcase
        end
    end

    // ---------------- next level ----------------
    always_comb
    begin
        env_level_next = env_level_reg;
        if (s1_go && s1_is_tick)
        begin
            case (phase_reg)
                adsr_pkg::PH_ATTACK:
                    env_level_next = reach_one ? adsr_pkg::ONE_FX[adsr_pkg::LEVEL_W-1:0]
                                               : step[adsr_pkg::LEVEL_W-1:0];
                adsr_pkg::PH_DECAY:
                    env_level_next = reach_sus ? sustain_level_reg
                                               : step[adsr_pkg::LEVEL_W-1:0];
                adsr_pkg::PH_SUSTAIN:
                    env_level_next = sustain_level_reg;
                adsr_pkg::PH_RELEASE:
                    env_level_next = reach_zero ? '0 : step[adsr_pkg::LEVEL_W-1:0];
                default:
                    env_level_next = '0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= adsr_pkg::PH_IDLE;
            env_level_reg     <= '0;
            gate_was_high_reg <= 1'b0;
            trig_was_high_reg <= 1'b0;
        end
        else
        begin
            phase_reg         <= phase_next;
            env_level_reg     <= env_level_next;
            gate_was_high_reg <= gate_was_high_next;
            trig_was_high_reg <= trig_was_high_next;
        end
    end

    // ---------------- output register ----------------
    always_comb
    begin
        if (s1_go && s1_is_tick)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && s1_is_tick)
            level_reg <= env_level_next;
    end

    assign out_valid = out_valid_reg;
    assign level     = level_reg;

`ifndef SYNTH
    // idle always sits at zero
    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == adsr_pkg::PH_IDLE |-> env_level_reg == '0)
        else $error("idle phase with nonzero level");

    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_go |=> s1_valid_reg && $stable(s1_func_reg)
                                   && $stable(s1_high_reg))
        else $error("held input word changed");

    a_tick_out: assert property (@(posedge clk) disable iff (!rst_n)
        s1_go && s1_is_tick |=> out_valid_reg && level_reg == env_level_reg)
        else $error("tick did not load the output register");

    a_out_drain: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_stall && !(s1_go && s1_is_tick) |=> !out_valid_reg)
        else $error("output word repeated");
`endif

endmodule

>>> verif/adsr_envelope_generator_unit_tb.sv
module adsr_envelope_generator_unit_tb;
    import adsr_pkg::*;

    localparam longint LVL_ONE = longint'(1) << FRAC_BITS;
    localparam longint LVL_EPS = (LVL_ONE + 500) / 1000;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int HOLD_CYCLES     = 150;
    localparam int PHASES          = 8;
    localparam int WORDS_PER_PHASE = 110;
    localparam int DIR_ROWS        = 26;
    localparam int DIR_SPLIT       = 14;

    // codes the block has no use for
    localparam logic [FUNC_W-1:0] FN_SPARE_5 = 3'd5;
    localparam logic [FUNC_W-1:0] FN_SPARE_6 = 3'd6;
    localparam logic [FUNC_W-1:0] FN_SPARE_7 = 3'd7;

    localparam logic signed [CV_W-1:0] CV_MAX   = {1'b0, {(CV_W-1){1'b1}}};
    localparam logic signed [CV_W-1:0] CV_MIN   = {1'b1, {(CV_W-1){1'b0}}};
    localparam logic signed [CV_W-1:0] CV_HALF  = CV_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [CV_W-1:0] CV_ABOVE = CV_HALF + 1;

    localparam logic [LEVEL_W-1:0] LEVEL_ZERO = '0;
    localparam logic [LEVEL_W-1:0] LEVEL_FULL = LEVEL_W'(1) << FRAC_BITS;
    localparam logic [LEVEL_W-1:0] TARGET_MAX = '1;
    localparam logic [COEFF_W-1:0] COEFF_MAX  = '1;

    typedef struct {
        logic [FUNC_W-1:0]      fn;
        logic signed [CV_W-1:0] cv;
        bit                     fixed;
        logic [LEVEL_W-1:0]     want;
    } word_t;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_IDX_W-1:0]      cfg_index;
    logic [LEVEL_W-1:0]        cfg_data;
    logic                      in_valid;
    logic                      in_stall;
    logic [FUNC_W-1:0]         func;
    logic signed [CV_W-1:0]    cv_value;
    logic                      out_valid;
    logic                      out_stall;
    logic [LEVEL_W-1:0]        level;

    // word on the input bus carries its own typed expectation, if any
    bit                        word_fixed;
    logic [LEVEL_W-1:0]        word_want;
    bit                        sending;

    word_t                     pending_words[$];
    logic [LEVEL_W-1:0]        due_levels[$];
    int                        mismatches;
    int                        hold_trips;
    int                        cycle_count;

    // envelope model: configuration and state
    logic [COEFF_W-1:0]        k_attack;
    logic [COEFF_W-1:0]        k_decay;
    logic [COEFF_W-1:0]        k_release;
    longint                    sustain_aim;
    longint                    attack_aim;
    longint                    release_aim;
    phase_t                    env_phase;
    longint                    env_lvl;
    bit                        gate_hi;
    bit                        trig_hi;

    word_t dir_rows [DIR_ROWS] = '{
        '{FN_TICK,     '0,       1'b1, LEVEL_ZERO},  // idle right after reset
        '{FN_NOTE_OFF, CV_MAX,   1'b0, '0},          // note off while idle
        '{FN_GATE,     CV_HALF,  1'b0, '0},          // exactly one half is still low
        '{FN_TICK,     CV_MIN,   1'b1, LEVEL_ZERO},
        '{FN_SPARE_5,  CV_MAX,   1'b0, '0},
        '{FN_SPARE_6,  CV_MIN,   1'b0, '0},
        '{FN_SPARE_7,  CV_ABOVE, 1'b0, '0},
        '{FN_TRIG,     CV_ABOVE, 1'b0, '0},          // trigger rising edge
        '{FN_TICK,     '0,       1'b0, '0},
        '{FN_TRIG,     CV_MAX,   1'b0, '0},          // held high, no edge
        '{FN_GATE,     CV_MAX,   1'b0, '0},          // gate rising, restart attack
        '{FN_TICK,     CV_MAX,   1'b0, '0},
        '{FN_GATE,     CV_MIN,   1'b0, '0},          // gate falling, release
        '{FN_TICK,     '0,       1'b0, '0},
        // instant segments from here on
        '{FN_NOTE_ON,  '0,       1'b0, '0},
        '{FN_TICK,     '0,       1'b1, LEVEL_FULL},
        '{FN_TICK,     '0,       1'b1, LEVEL_FULL},
        '{FN_TICK,     '0,       1'b1, LEVEL_FULL},
        '{FN_NOTE_ON,  CV_MIN,   1'b0, '0},          // note on while active
        '{FN_TICK,     '0,       1'b1, LEVEL_FULL},
        '{FN_GATE,     CV_ABOVE, 1'b0, '0},
        '{FN_TICK,     '0,       1'b1, LEVEL_FULL},
        '{FN_NOTE_OFF, '0,       1'b0, '0},
        '{FN_TICK,     '0,       1'b1, LEVEL_ZERO},
        '{FN_GATE,     '0,       1'b0, '0},          // gate falling while idle
        '{FN_TICK,     CV_MAX,   1'b1, LEVEL_ZERO}
    };

    adsr_envelope_generator_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .cv_value  (cv_value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .level     (level)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input logic [LEVEL_W-1:0] got,
                                   input logic [LEVEL_W-1:0] want);
        mismatches++;
        if (mismatches <= 40)
            $display("mismatch @%0t: %s got %0d want %0d", $time, what, got, want);
    endtask

    // aim + round(k * (lvl - aim)), ties toward +inf
    function automatic longint pole_next(input logic [COEFF_W-1:0] k, input longint lvl,
                                         input longint aim);
        longint c;
        c = longint'(k);
        if (c >= LVL_ONE)
            c = LVL_ONE - 1;
        return aim + ((c * (lvl - aim) + LVL_ONE / 2) >>> FRAC_BITS);
    endfunction

    task automatic envelope_tick();
        case (env_phase)
            PH_ATTACK:
            begin
                env_lvl = pole_next(k_attack, env_lvl, attack_aim);
                if (env_lvl >= LVL_ONE)
                begin
                    env_lvl   = LVL_ONE;
                    env_phase = PH_DECAY;
                end
            end
            PH_DECAY:
            begin
                env_lvl = pole_next(k_decay, env_lvl, sustain_aim - LVL_EPS);
                if (env_lvl <= sustain_aim)
                begin
                    env_lvl   = sustain_aim;
                    env_phase = PH_SUSTAIN;
                end
            end
            PH_SUSTAIN:
                env_lvl = sustain_aim;
            PH_RELEASE:
            begin
                env_lvl = pole_next(k_release, env_lvl, release_aim);
                if (env_lvl <= 0)
                begin
                    env_lvl   = 0;
                    env_phase = PH_IDLE;
                end
            end
            default:
            begin
                env_lvl   = 0;
                env_phase = PH_IDLE;
            end
        endcase
    endtask

    task automatic apply_word(input logic [FUNC_W-1:0] fn, input logic signed [CV_W-1:0] cv,
                              output bit made, output logic [LEVEL_W-1:0] lvl_out);
        bit high;
        high    = cv > CV_HALF;
        made    = 1'b0;
        lvl_out = '0;
        case (fn)
            FN_TICK:
            begin
                envelope_tick();
                made    = 1'b1;
                lvl_out = env_lvl[LEVEL_W-1:0];
            end
            FN_GATE:
            begin
                if (high && !gate_hi)
                    env_phase = PH_ATTACK;
                else if (!high && gate_hi && env_phase != PH_IDLE)
                    env_phase = PH_RELEASE;
                gate_hi = high;
            end
            FN_TRIG:
            begin
                if (high && !trig_hi)
                    env_phase = PH_ATTACK;
                trig_hi = high;
            end
            FN_NOTE_ON:
                env_phase = PH_ATTACK;
            FN_NOTE_OFF:
                if (env_phase != PH_IDLE)
                    env_phase = PH_RELEASE;
            default:
                ;
        endcase
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LEVEL_W-1:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_ATTACK_COEFF:   k_attack    = data[COEFF_W-1:0];
            REG_DECAY_COEFF:    k_decay     = data[COEFF_W-1:0];
            REG_RELEASE_COEFF:  k_release   = data[COEFF_W-1:0];
            REG_SUSTAIN_LEVEL:  sustain_aim = longint'(data);
            REG_ATTACK_TARGET:  attack_aim  = longint'(data);
            REG_RELEASE_TARGET: release_aim = longint'($signed(data));
            default:            ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // drain input and output, then give the pipe time to empty
    task automatic settle();
        while (pending_words.size() != 0 || sending)
            @(posedge clk);
        while (due_levels.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic add_word(input logic [FUNC_W-1:0] fn, input logic signed [CV_W-1:0] cv);
        word_t w;
        w.fn    = fn;
        w.cv    = cv;
        w.fixed = 1'b0;
        w.want  = '0;
        pending_words.push_back(w);
    endtask

    function automatic logic [COEFF_W-1:0] pick_coeff();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return COEFF_MAX;
            2:       return COEFF_W'($urandom_range(24'hF00000, 24'hFFFFFF));
            default: return COEFF_W'($urandom_range(0, 24'hD00000));
        endcase
    endfunction

    function automatic logic signed [CV_W-1:0] cv_high();
        if ($urandom_range(0, 5) == 0)
            return CV_ABOVE;
        return CV_W'($urandom_range(CV_ABOVE, CV_MAX));
    endfunction

    function automatic logic signed [CV_W-1:0] cv_low();
        case ($urandom_range(0, 5))
            0:       return CV_HALF;
            1, 2:    return CV_W'($urandom) | CV_MIN;
            default: return CV_W'($urandom_range(0, CV_HALF));
        endcase
    endfunction

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge clk)
    begin : scoreboard
        bit                 made;
        logic [LEVEL_W-1:0] lvl;
        logic [LEVEL_W-1:0] want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (due_levels.size() == 0)
                    report_mismatch("level word with none pending", level, '0);
                else
                begin
                    want = due_levels.pop_front();
                    if (level !== want)
                        report_mismatch("level", level, want);
                end
            end
            if (in_valid && !in_stall)
            begin
                apply_word(func, cv_value, made, lvl);
                if (made)
                    due_levels.push_back(word_fixed ? word_want : lvl);
            end
        end
    end

    initial
    begin : sender
        word_t w;
        int    burst_left;
        int    gap_left;
        in_valid   = 1'b0;
        func       = '0;
        cv_value   = '0;
        word_fixed = 1'b0;
        word_want  = '0;
        sending    = 1'b0;
        burst_left = 1;
        gap_left   = 0;
        forever
        begin
            @(negedge clk);
            if (gap_left > 0 || pending_words.size() == 0)
            begin
                in_valid = 1'b0;
                func     = FUNC_W'($urandom);
                cv_value = CV_W'($urandom);
                sending  = 1'b0;
                if (gap_left > 0)
                    gap_left--;
            end
            else
            begin
                w          = pending_words.pop_front();
                in_valid   = 1'b1;
                func       = w.fn;
                cv_value   = w.cv;
                word_fixed = w.fixed;
                word_want  = w.want;
                sending    = 1'b1;
                do @(posedge clk); while (in_stall);
                burst_left--;
                if (burst_left == 0)
                begin
                    // now and then a long back-to-back run
                    if ($urandom_range(0, 4) == 0)
                    begin
                        burst_left = $urandom_range(40, 120);
                        gap_left   = 0;
                    end
                    else
                    begin
                        burst_left = $urandom_range(1, 12);
                        gap_left   = $urandom_range(1, 7);
                    end
                end
            end
        end
    end

    initial
    begin : receiver
        int mode;
        int mode_left;
        int hold_left;
        int trips_seen;
        out_stall  = 1'b0;
        mode       = 0;
        mode_left  = 0;
        hold_left  = 0;
        trips_seen = 0;
        forever
        begin
            @(negedge clk);
            if (hold_trips != trips_seen)
            begin
                trips_seen = hold_trips;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_stall = 1'b1;
                hold_left--;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 150);
                end
                mode_left--;
                case (mode)
                    0:       out_stall = 1'b0;
                    1:       out_stall = $urandom_range(0, 2) == 0;
                    2:       out_stall = ~out_stall;
                    default: out_stall = $urandom_range(0, 4) != 0;
                endcase
            end
        end
    end

    initial
    begin : main
        int                 n;
        int                 reps;
        logic [FUNC_W-1:0]  fn;
        logic [COEFF_W-1:0] ka;
        logic [COEFF_W-1:0] kd;
        logic [COEFF_W-1:0] kr;
        logic [LEVEL_W-1:0] sus;
        logic [LEVEL_W-1:0] at;
        logic [LEVEL_W-1:0] rt;
        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        mismatches  = 0;
        hold_trips  = 0;
        cycle_count = 0;
        k_attack    = RST_ATTACK_COEFF;
        k_decay     = RST_DECAY_COEFF;
        k_release   = RST_RELEASE_COEFF;
        sustain_aim = longint'(RST_SUSTAIN_LEVEL);
        attack_aim  = longint'(RST_ATTACK_TARGET);
        release_aim = longint'(RST_RELEASE_TARGET);
        env_phase   = PH_IDLE;
        env_lvl     = 0;
        gate_hi     = 1'b0;
        trig_hi     = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            if (i == DIR_SPLIT)
            begin
                settle();
                write_reg(REG_ATTACK_COEFF, '0);
                write_reg(REG_DECAY_COEFF, '0);
                write_reg(REG_RELEASE_COEFF, '0);
                write_reg(REG_SUSTAIN_LEVEL, LEVEL_FULL);
                write_reg(REG_ATTACK_TARGET, TARGET_MAX);
                write_reg(REG_RELEASE_TARGET, LEVEL_W'(-LVL_ONE));
            end
            pending_words.push_back(dir_rows[i]);
        end
        settle();

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                1:
                begin
                    ka  = COEFF_MAX;
                    kd  = COEFF_MAX;
                    kr  = COEFF_MAX;
                    sus = LEVEL_ZERO;
                    at  = LEVEL_FULL;
                    rt  = '0;
                end
                2:
                begin
                    ka  = '0;
                    kd  = '0;
                    kr  = '0;
                    sus = LEVEL_FULL;
                    at  = TARGET_MAX;
                    rt  = LEVEL_W'(-LVL_ONE);
                end
                default:
                begin
                    ka  = pick_coeff();
                    kd  = pick_coeff();
                    kr  = pick_coeff();
                    sus = LEVEL_W'($urandom_range(0, LVL_ONE));
                    at  = LEVEL_W'($urandom_range(LVL_ONE, TARGET_MAX));
                    rt  = LEVEL_W'(-longint'($urandom_range(0, LVL_ONE)));
                end
            endcase
            write_reg(REG_ATTACK_COEFF, LEVEL_W'(ka));
            write_reg(REG_DECAY_COEFF, LEVEL_W'(kd));
            write_reg(REG_RELEASE_COEFF, LEVEL_W'(kr));
            write_reg(REG_SUSTAIN_LEVEL, sus);
            write_reg(REG_ATTACK_TARGET, at);
            write_reg(REG_RELEASE_TARGET, rt);
            // block the output for a while so the input backs up
            if (p == 3)
                hold_trips++;

            n = 0;
            while (n < WORDS_PER_PHASE)
            begin
                if ($urandom_range(0, 6) == 0)
                begin
                    fn = FUNC_W'($urandom_range(0, 7));
                    add_word(fn, CV_W'($urandom));
                    if (fn <= FN_NOTE_OFF)
                        n++;
                end
                else
                begin
                    // onset, a run of ticks, usually a release, another run of ticks
                    case ($urandom_range(0, 2))
                        0:
                            add_word(FN_NOTE_ON, CV_W'($urandom));
                        1:
                        begin
                            add_word(FN_GATE, cv_low());
                            add_word(FN_GATE, cv_high());
                            n++;
                        end
                        default:
                        begin
                            add_word(FN_TRIG, cv_low());
                            add_word(FN_TRIG, cv_high());
                            n++;
                        end
                    endcase
                    reps = $urandom_range(0, 24);
                    repeat (reps) add_word(FN_TICK, CV_W'($urandom));
                    n += reps + 1;
                    case ($urandom_range(0, 3))
                        0:       add_word(FN_GATE, cv_low());
                        1:       ;
                        default: add_word(FN_NOTE_OFF, CV_W'($urandom));
                    endcase
                    reps = $urandom_range(0, 30);
                    repeat (reps) add_word(FN_TICK, CV_W'($urandom));
                    n += reps + 1;
                end
            end
            settle();
        end

        if (due_levels.size() != 0)
            report_mismatch("level words never delivered", '0, LEVEL_W'(due_levels.size()));
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
